/* rtl/sbsh_pkg.sv */
package sbsh_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_CHAIN = 8;
    localparam int unsigned NUM_SCHED = 16;
    localparam int unsigned NUM_ROUND = 64;
    localparam int unsigned LEN_W     = 64;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] FILL_LAST   = 6'd63;
    localparam logic [LEN_W-1:0] BLOCK_BITS = 64'd512;

    typedef logic [WORD_W-1:0] word_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        case (idx)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_const(input logic [5:0] idx);
        case (idx)
            6'd0:  round_const = 32'h428a2f98;  6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf;  6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b;  6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4;  6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98;  6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be;  6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74;  6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7;  6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1;  6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6;  6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f;  6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc;  6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152;  6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8;  6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3;  6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351;  6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85;  6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc;  6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354;  6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e;  6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1;  6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70;  6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819;  6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585;  6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116;  6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c;  6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3;  6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f;  6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee;  6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814;  6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa;  6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7;
            default: round_const = 32'hc67178f2;
        endcase
    endfunction

endpackage

/* rtl/sha256_byte_stream_hasher.sv */
// Channel  Dir  Ports                                          Carries
// s_       in   s_valid s_ready s_cmd s_data_byte              one byte or a finish request
// m_       out  m_valid m_ready m_digest_word m_word_index     digest words, index 0 first
//                m_last_word
// An absorb request stores one byte; the 64th byte of a block starts a compression
// (64 rounds of the shared round unit plus one chaining add).
// A finish request pads and appends the length byte by byte,
// runs one or two compressions, then presents 8 words at one per cycle while m_ready is high.
// s_ready is low from the finish request until the eighth word is taken and
// during every compression; a stalled m_ready holds the current word.
// aresetn (synchronous) restores the initial hash, zero length and empty block.
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_COMP = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [5:0] ROUND_LAST = 6'(NUM_ROUND - 1);

    logic [2:0]       state_reg, state_next;
    logic [2:0]       ret_reg, ret_next;
    logic [5:0]       fill_reg, fill_next;
    logic [LEN_W-1:0] bit_length_reg, bit_length_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [5:0]       round_reg, round_next;
    logic [2:0]       out_idx_reg, out_idx_next;
    word_t            chain_reg [NUM_CHAIN];
    word_t            chain_next [NUM_CHAIN];
    word_t            v_reg [NUM_CHAIN];
    word_t            v_next [NUM_CHAIN];
    word_t            w_reg [NUM_SCHED];
    word_t            w_next [NUM_SCHED];

    logic       push_en;
    logic [7:0] push_data;
    logic       start_comp;
    word_t      t1, t2, w_new;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_const(round_reg) + w_reg[0];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        fill_next       = fill_reg;
        bit_length_next = bit_length_reg;
        total_next      = total_reg;
        round_next      = round_reg;
        out_idx_next    = out_idx_reg;
        chain_next      = chain_reg;
        v_next          = v_reg;
        w_next          = w_reg;
        push_en         = 1'b0;
        push_data       = 8'h00;
        start_comp      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    push_en = 1'b1;
                    if (s_cmd == CMD_ABSORB) begin
                        push_data = s_data_byte;
                        ret_next  = ST_IDLE;
                    end else begin
                        push_data  = PAD_BYTE;
                        ret_next   = ST_PAD;
                        state_next = ST_PAD;
                        total_next = bit_length_reg + {{(LEN_W-9){1'b0}}, fill_reg, 3'b000};
                    end
                    start_comp = (fill_reg == FILL_LAST);
                end
            end
            ST_PAD: begin
                if (fill_reg == LEN_POS) begin
                    state_next = ST_LEN;
                end else begin
                    push_en    = 1'b1;
                    push_data  = 8'h00;
                    start_comp = (fill_reg == FILL_LAST);
                end
            end
            ST_LEN: begin
                push_en    = 1'b1;
                push_data  = total_reg[LEN_W-1 -: 8];
                total_next = total_reg << 8;
                ret_next   = ST_OUT;
                start_comp = (fill_reg == FILL_LAST);
            end
            ST_COMP: begin
                for (int i = 0; i < NUM_SCHED - 1; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[NUM_SCHED-1] = w_new;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                round_next = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < NUM_CHAIN; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                bit_length_next = bit_length_reg + BLOCK_BITS;
                out_idx_next    = 3'd0;
                state_next      = ret_reg;
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7) begin
                        for (int i = 0; i < NUM_CHAIN; i++) begin
                            chain_next[i] = init_hash(3'(i));
                        end
                        bit_length_next = '0;
                        fill_next       = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (push_en) begin
            w_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = push_data;
            fill_next = fill_reg + 6'd1;
        end

        if (start_comp) begin
            v_next     = chain_reg;
            round_next = '0;
            state_next = ST_COMP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            fill_reg       <= '0;
            bit_length_reg <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            for (int i = 0; i < NUM_CHAIN; i++) begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            fill_reg       <= fill_next;
            bit_length_reg <= bit_length_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            chain_reg      <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while digest pending");

    a_round_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP && round_reg != ROUND_LAST)
            |=> (state_reg == ST_COMP && round_reg == $past(round_reg) + 6'd1))
        else $error("compression round sequence broken");

    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> (fill_reg[5:3] == 3'b111))
        else $error("length bytes outside tail of block");

    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word)
            |=> (fill_reg == '0 && bit_length_reg == '0 && s_ready))
        else $error("state not cleared after digest");
`endif

endmodule

/* dv/sha256_digest_checker.sv */
`timescale 1ns / 1ps

module sha256_digest_checker
    import sbsh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_digest_word,
    input  logic [2:0]  m_word_index,
    input  logic        m_last_word,
    output int          mismatch_count,
    output int          pending_words
);

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } digest_entry_t;

    localparam word_t SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    word_t         hash_state [8];
    logic [7:0]    msg_block [64];
    int unsigned   block_fill;
    logic [63:0]   done_bits;
    digest_entry_t expected_digest_q [$];
    int            mismatches;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_state = SHA_IV;
        for (int i = 0; i < 64; i++) begin
            msg_block[i] = 8'h00;
        end
        block_fill = 0;
        done_bits  = 64'd0;
    endfunction

    function automatic void fold_block();
        word_t sched [64];
        word_t v [8];
        word_t s0;
        word_t s1;
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++) begin
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
        end
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            fold_block();
            done_bits  = done_bits + 64'd512;
            block_fill = 0;
        end
    endfunction

    function automatic void finish_message();
        logic [63:0] msg_bits;
        msg_bits = done_bits + 64'(block_fill) * 64'd8;
        absorb_byte(PAD_BYTE);
        while (block_fill != 56) begin
            absorb_byte(8'h00);
        end
        for (int i = 0; i < 8; i++) begin
            absorb_byte(msg_bits[63 - 8*i -: 8]);
        end
        for (int i = 0; i < 8; i++) begin
            expected_digest_q.insert(expected_digest_q.size(),
                                     digest_entry_t'{hash_state[i], 3'(i), (i == 7)});
        end
        restart_hash();
    endfunction

    always @(posedge aclk) begin
        digest_entry_t want;
        if (!aresetn) begin
            restart_hash();
            expected_digest_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_digest_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected digest word %08h index %0d last %b",
                                 m_digest_word, m_word_index, m_last_word);
                    end
                end else begin
                    want = expected_digest_q.pop_front();
                    if (m_digest_word !== want.digest_word || m_word_index !== want.word_index ||
                        m_last_word !== want.last_word) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("digest mismatch: expected %08h/%0d/%b, got %08h/%0d/%b",
                                     want.digest_word, want.word_index, want.last_word,
                                     m_digest_word, m_word_index, m_last_word);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_FINISH) begin
                    finish_message();
                end else begin
                    absorb_byte(s_data_byte);
                end
            end
        end
        mismatch_count <= mismatches;
        pending_words  <= expected_digest_q.size();
    end

endmodule

/* dv/tb_sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;
    import sbsh_pkg::*;

    localparam int RANDOM_REQUESTS = 500;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 64;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int BOUNDARY_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_DENSE
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    int mismatch_count;
    int pending_words;
    int words_taken;
    int idle_cycles;
    int burst_left;
    int requests_sent;

    sha256_byte_stream_hasher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    sha256_digest_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            words_taken <= 0;
            idle_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                words_taken <= words_taken + 1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        bit       hold_done;
        m_ready   = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && words_taken >= HOLD_AFTER) begin
                // hold off long enough for the block to back up into its input
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic offer_request(input logic cmd, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            offer_request(CMD_ABSORB, 8'($urandom_range(0, 255)));
        end
        offer_request(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        int unsigned pick;
        int unsigned len;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = CMD_ABSORB;
        s_data_byte   = 8'h00;
        burst_left    = 0;
        requests_sent = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty message
        offer_request(CMD_FINISH, 8'h00);
        // "abc", finish carries a byte that must be dropped
        offer_request(CMD_ABSORB, 8'h61);
        offer_request(CMD_ABSORB, 8'h62);
        offer_request(CMD_ABSORB, 8'h63);
        offer_request(CMD_FINISH, 8'hff);
        offer_request(CMD_ABSORB, 8'h00);
        offer_request(CMD_FINISH, 8'h00);
        offer_request(CMD_ABSORB, 8'hff);
        offer_request(CMD_FINISH, 8'h55);
        offer_request(CMD_ABSORB, 8'h80);
        offer_request(CMD_ABSORB, 8'h7f);
        offer_request(CMD_ABSORB, 8'haa);
        offer_request(CMD_FINISH, 8'h01);

        while (requests_sent < RANDOM_REQUESTS + 13) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len = $urandom_range(0, 24);
            end else if (pick < 9) begin
                len = BOUNDARY_LEN[$urandom_range(0, 8)];
            end else begin
                len = $urandom_range(0, 140);
            end
            send_message(len);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_words != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
